>>> hdl/dtms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtms_pkg
// Shared types, codes and sizes for the device table with masked search.
// ----------------------------------------------------------------------------
package dtms_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int START_W     = 6;
	localparam int CMP_W       = (CNT_W > START_W) ? CNT_W : START_W;
	localparam int ENTRY_W     = 5;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  start_index;
		logic [4:0]  wildcard_mask;
		logic [7:0]  class_code;
		logic [7:0]  subclass_code;
		logic [7:0]  bus_number;
		logic [4:0]  slot_number;
		logic [2:0]  function_number;
		logic [15:0] vendor_code;
		logic [15:0] product_code;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  entry_index;
		logic [7:0]  found_class;
		logic [7:0]  found_subclass;
		logic [7:0]  found_bus;
		logic [4:0]  found_slot;
		logic [2:0]  found_function;
		logic [15:0] found_vendor;
		logic [15:0] found_product;
	} rsp_item_t;

	typedef struct packed {
		logic [15:0] vendor;
		logic [15:0] product;
		logic [7:0]  class_code;
		logic [7:0]  subclass_code;
		logic [7:0]  bus;
		logic [4:0]  slot;
		logic [2:0]  func;
	} record_t;

	typedef enum logic [2:0] {
		RES_DONE,
		RES_INSERTED,
		RES_FULL,
		RES_MISS,
		RES_HIT
	} res_sel_t;

	typedef struct packed {
		logic     load_item;
		logic     clear_all;
		logic     step_idx;
		logic     ins_write;
		logic     issue_read;
		logic     res_set;
		res_sel_t res_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic past_end;
		logic slot_free;
		logic idx_last;
		logic idx_in_range;
		logic hit_s1;
		logic last_s1;
	} dp_status_t;

endpackage
`default_nettype wire

>>> hdl/dtms_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtms_datapath
// Valid marks, record store, scan index, key compare and result registers.
// ----------------------------------------------------------------------------
module dtms_datapath import dtms_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  req_item_t  req,
	input  dp_cmd_t    cmd,
	output dp_status_t st,
	output rsp_item_t  rsp
);

	req_item_t              item_q;
	logic [CNT_W-1:0]       idx_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	record_t                mem [TABLE_DEPTH];
	record_t                rec_s1;
	logic                   vld_s1;
	logic                   rd_s1;
	logic [IDX_W-1:0]       idx_s1;
	rsp_item_t              res_q;
	rsp_item_t              out_q;
	rsp_item_t              res_d;
	logic [CMP_W-1:0]       start_ext;
	logic [IDX_W-1:0]       addr;
	logic                   key_match;

	assign start_ext = CMP_W'(req.start_index);
	assign addr      = idx_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_item) begin
			idx_q <= (req.operation == OP_FIND) ? start_ext[CNT_W-1:0] : '0;
		end else if (cmd.step_idx || cmd.issue_read) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_all) begin
			valid_q <= '0;
		end else if (cmd.ins_write) begin
			valid_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			mem[addr] <= '{vendor: item_q.vendor_code, product: item_q.product_code,
				class_code: item_q.class_code, subclass_code: item_q.subclass_code,
				bus: item_q.bus_number, slot: item_q.slot_number,
				func: item_q.function_number};
		end
		if (cmd.issue_read) begin
			rec_s1 <= mem[addr];
			vld_s1 <= valid_q[addr];
			idx_s1 <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.issue_read;
		end
	end

	always_comb begin
		key_match = (item_q.wildcard_mask[0] || rec_s1.class_code == item_q.class_code)
			&& (item_q.wildcard_mask[1] || rec_s1.subclass_code == item_q.subclass_code)
			&& (item_q.wildcard_mask[2] || rec_s1.bus == item_q.bus_number)
			&& (item_q.wildcard_mask[3] || rec_s1.slot == item_q.slot_number)
			&& (item_q.wildcard_mask[4] || rec_s1.func == item_q.function_number);
	end

	always_comb begin
		st.past_end     = start_ext >= CMP_W'(TABLE_DEPTH);
		st.slot_free    = !valid_q[addr];
		st.idx_last     = idx_q == CNT_W'(TABLE_DEPTH - 1);
		st.idx_in_range = idx_q < CNT_W'(TABLE_DEPTH);
		st.hit_s1       = rd_s1 && vld_s1 && key_match;
		st.last_s1      = rd_s1 && (idx_s1 == IDX_W'(TABLE_DEPTH - 1));
	end

	always_comb begin
		res_d = '0;
		case (cmd.res_sel)
			RES_DONE: begin
				res_d.status = ST_OK;
			end
			RES_INSERTED: begin
				res_d.status      = ST_OK;
				res_d.entry_index = ENTRY_W'(addr);
			end
			RES_FULL: begin
				res_d.status = ST_FULL;
			end
			RES_MISS: begin
				res_d.status = ST_NOT_FOUND;
			end
			RES_HIT: begin
				res_d.status         = ST_OK;
				res_d.entry_index    = ENTRY_W'(idx_s1);
				res_d.found_class    = rec_s1.class_code;
				res_d.found_subclass = rec_s1.subclass_code;
				res_d.found_bus      = rec_s1.bus;
				res_d.found_slot     = rec_s1.slot;
				res_d.found_function = rec_s1.func;
				res_d.found_vendor   = rec_s1.vendor;
				res_d.found_product  = rec_s1.product;
			end
			default: begin
				res_d.status = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp = out_q;

endmodule
`default_nettype wire

>>> hdl/dtms_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtms_ctrl
// Operation sequencer: dispatch, insert slot walk, find scan, result handoff.
// ----------------------------------------------------------------------------
module dtms_ctrl import dtms_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	output logic       req_ready,
	input  wire  [1:0] op,
	output logic       rsp_valid,
	input  wire        rsp_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_INSERT,
		S_FIND,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) || (state_q == S_DONE && out_free);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_INSERT: begin
				if (st.slot_free) begin
					cmd.ins_write = 1'b1;
					cmd.res_set   = 1'b1;
					cmd.res_sel   = RES_INSERTED;
					state_d       = S_DONE;
				end else if (st.idx_last) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_FULL;
					state_d     = S_DONE;
				end else begin
					cmd.step_idx = 1'b1;
				end
			end
			S_FIND: begin
				if (st.hit_s1) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_HIT;
					state_d     = S_DONE;
				end else if (st.last_s1) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_MISS;
					state_d     = S_DONE;
				end else begin
					cmd.issue_read = st.idx_in_range;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (accept) begin
			cmd.load_item = 1'b1;
			case (op)
				OP_CLEAR: begin
					cmd.clear_all = 1'b1;
					cmd.res_set   = 1'b1;
					cmd.res_sel   = RES_DONE;
					state_d       = S_DONE;
				end
				OP_INSERT: begin
					state_d = S_INSERT;
				end
				OP_FIND: begin
					if (st.past_end) begin
						cmd.res_set = 1'b1;
						cmd.res_sel = RES_MISS;
						state_d     = S_DONE;
					end else begin
						state_d = S_FIND;
					end
				end
				default: begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_MISS;
					state_d     = S_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_ins_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_write |-> (st.slot_free && state_q == S_INSERT))
		else $error("insert write to an occupied slot");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("response beat raised outside result handoff");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue_read |-> st.idx_in_range)
		else $error("scan read past table end");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> (st.idx_in_range || st.last_s1 || st.hit_s1))
		else $error("find scan stalled without a result");

endmodule
`default_nettype wire

>>> hdl/device_table_masked_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// device_table_masked_search
// Device record table: clear, insert in first free slot, masked find.
//
//   channel  signals                         payload
//   req      req_valid / req_ready / req     req_item_t
//   rsp      rsp_valid / rsp_ready / rsp     rsp_item_t
//
// Clear and unused codes go straight to the response handoff, with no table walk.
// Insert walks the valid marks one slot per cycle from slot 0 and stops at the
// first free slot, or after the last slot when full. Find reads the record store
// one entry per cycle from start_index until a hit or the last entry.
// One operation in flight; the next request beat is taken in the cycle the
// response register is loaded. Reset clears valid marks and control only.
// ----------------------------------------------------------------------------
module device_table_masked_search import dtms_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  wire       rsp_ready,
	output rsp_item_t rsp
);

	dp_cmd_t    cmd;
	dp_status_t st;

	dtms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.op        (req.operation),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.st        (st),
		.cmd       (cmd)
	);

	dtms_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
